>>> sv/srp_pkg.sv
// Shared constants, codes and types for the servo ramp positioner.
// Used by the controller, datapath, divider and top level; depends on nothing.
package srp_pkg;

    localparam int PW_W       = 12;
    localparam int DELAY_W    = 16;
    localparam int MARGIN_W   = 7;
    localparam int ANGLE_W    = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared divider: magnitude dividend, 12-bit divisor, two quotient bits per cycle
    localparam int PROD_W    = 28;
    localparam int DIVR_W    = 12;
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PW_W-1:0]     RST_MIN_PULSE = 12'd544;
    localparam logic [PW_W-1:0]     RST_MAX_PULSE = 12'd2400;
    localparam logic [PW_W-1:0]     RST_MID_PULSE = 12'd1472;
    localparam logic [DELAY_W-1:0]  RST_MIN_DELAY = 16'd1000;
    localparam logic [DELAY_W-1:0]  RST_MAX_DELAY = 16'd5000;
    localparam logic [MARGIN_W-1:0] RST_MARGIN    = 7'd0;
    localparam logic [MARGIN_W-1:0] MARGIN_MAX    = 7'd89;
    localparam logic signed [ANGLE_W-1:0] HALF_SPAN = 8'sd90;
    localparam logic [ANGLE_W-1:0]  FULL_SPAN     = 8'd180;

    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAMP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JUMP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_DMUL,
        OP_AMUL,
        OP_BMUL,
        OP_DIV_GO,
        OP_DFIN,
        OP_AFIN,
        OP_BFIN,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DMUL,
        S_DGO,
        S_DWAIT,
        S_AGO,
        S_AWAIT,
        S_BMUL,
        S_BGO,
        S_BWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              step_now;
        logic              div_done;
        logic              out_free;
    } t_dp_stat;

endpackage

>>> sv/servo_ramp_positioner_core.sv
// Top level of the servo pulse-width ramp positioner.
// Depends on srp_pkg, srp_ctrl, srp_datapath (which holds srp_divider).
//
// Usage:
//   Input channel (i_valid / o_stall, i_mode, i_target_angle): one beat per item.
//   Mode tick counts one microsecond of ramp time, ramp sets a new target
//   from an angle, jump sets the width at once. Output channel
//   (o_valid / i_stall) returns exactly one result beat per input beat,
//   in order: pulse width, changed flag, moving flag and width mapped back to
//   degrees.
//   A tick that takes no step and the unused mode run one division, the back
//   map; a tick that steps and a ramp or jump run two. Each division runs on
//   one shared restoring divider at two quotient bits per cycle, and the
//   block takes a new beat only after the last one is done.
//   The result sits in an output register, so a stalled receiver does not
//   hold the input side: the next beat is taken and worked on, and the block
//   holds in its final step only if the previous result is still unread.
//   Reset (synchronous, active low) restores the register defaults, sets the
//   width, ramp start and target to the midpoint 1472 us and clears the wait.
//   Write config (i_cfg_we, i_cfg_index, i_cfg_data) only while idle.
module servo_ramp_positioner_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [srp_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [srp_pkg::ANGLE_W-1:0]  i_target_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [srp_pkg::PW_W-1:0]            o_pulse_us,
    output logic                                o_pulse_changed,
    output logic                                o_moving,
    output logic signed [srp_pkg::ANGLE_W-1:0]  o_current_angle,
    input  logic                                i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import srp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each beat: capture, tick or angle map, delay reload, back map.
    srp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Hold config and servo state, do the multiply/divide work, drive results.
    srp_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_target_angle  (i_target_angle),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pulse_us      (o_pulse_us),
        .o_pulse_changed (o_pulse_changed),
        .o_moving        (o_moving),
        .o_current_angle (o_current_angle)
    );

endmodule

>>> sv/srp_divider.sv
// Shared restoring divider: unsigned 28-bit dividend by 12-bit divisor, two bits a cycle.
// Depends on srp_pkg.
module srp_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [srp_pkg::PROD_W-1:0]  i_dividend,
    input  logic [srp_pkg::DIVR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [srp_pkg::PROD_W-1:0]  o_quotient
);
    import srp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVR_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIVR_W+PROD_W-1:0] n_step1;
    logic [DIVR_W+PROD_W-1:0] n_step2;

    function automatic logic [DIVR_W+PROD_W-1:0] div_step(
        input logic [DIVR_W-1:0] rem,
        input logic [PROD_W-1:0] quo,
        input logic [DIVR_W-1:0] dvs
    );
        logic [DIVR_W:0] trial;
        logic [DIVR_W:0] diff;
        trial = {rem, quo[PROD_W-1]};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            return {diff[DIVR_W-1:0], quo[PROD_W-2:0], 1'b1};
        end else begin
            return {trial[DIVR_W-1:0], quo[PROD_W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        n_step1 = div_step(r_rem, r_quo, i_divisor);
        n_step2 = div_step(n_step1[DIVR_W+PROD_W-1:PROD_W], n_step1[PROD_W-1:0], i_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_step2[DIVR_W+PROD_W-1:PROD_W];
            r_quo <= n_step2[PROD_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/srp_datapath.sv
// Datapath: config registers, servo state, shared multiplier, divider and output register.
// Depends on srp_pkg and srp_divider; driven by srp_ctrl through t_dp_cmd.
module srp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srp_pkg::t_dp_cmd                    i_cmd,
    output srp_pkg::t_dp_stat                   o_stat,
    input  logic                                i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [srp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [srp_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [srp_pkg::ANGLE_W-1:0]  i_target_angle,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [srp_pkg::PW_W-1:0]            o_pulse_us,
    output logic                                o_pulse_changed,
    output logic                                o_moving,
    output logic signed [srp_pkg::ANGLE_W-1:0]  o_current_angle
);
    import srp_pkg::*;

    // configuration
    logic [PW_W-1:0]     r_min_pulse;
    logic [PW_W-1:0]     r_max_pulse;
    logic [DELAY_W-1:0]  r_min_delay;
    logic [DELAY_W-1:0]  r_max_delay;
    logic [MARGIN_W-1:0] r_margin;

    // servo state
    logic [PW_W-1:0]     r_pw;
    logic [PW_W-1:0]     r_start;
    logic [PW_W-1:0]     r_target;
    logic [DELAY_W-1:0]  r_wait;

    // captured beat
    logic [MODE_W-1:0]         r_mode;
    logic signed [ANGLE_W-1:0] r_angle;
    logic [PW_W-1:0]           r_old_pw;

    // arithmetic
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic [DIVR_W-1:0]         r_divisor;
    logic                      r_den_zero;
    logic signed [ANGLE_W-1:0] r_cur_angle;

    // output register
    logic                      r_out_valid;
    logic [PW_W-1:0]           r_out_pw;
    logic                      r_out_changed;
    logic                      r_out_moving;
    logic signed [ANGLE_W-1:0] r_out_angle;

    logic [MARGIN_W-1:0]       m_eff;
    logic signed [ANGLE_W-1:0] ang_lo;
    logic signed [ANGLE_W-1:0] ang_hi;
    logic [ANGLE_W-1:0]        ang_span;
    logic signed [ANGLE_W-1:0] ang_clamp;
    logic [ANGLE_W-1:0]        ang_off;
    logic signed [PW_W:0]      d_pulse;
    logic signed [PW_W:0]      d_ps;
    logic signed [PW_W:0]      d_ts;
    logic signed [PW_W:0]      d_pwmax;
    logic signed [DELAY_W:0]   d_delay;
    logic [DELAY_W-1:0]        wait_dec;
    logic                      step_now;
    logic [DELAY_W-1:0]        mul_a;
    logic [PW_W-1:0]           mul_b;
    logic [PROD_W-1:0]         prod;
    logic                      n_neg;
    logic [DIVR_W-1:0]         n_divisor;
    logic                      n_den_zero;
    logic [PROD_W-1:0]         quo;
    logic                      div_done;
    logic signed [PROD_W+1:0]  q_s;
    logic signed [PROD_W+1:0]  d_sum;
    logic signed [PROD_W+1:0]  a_sum;
    logic [DELAY_W-1:0]        n_wait;
    logic [PW_W-1:0]           w_new;
    logic signed [ANGLE_W-1:0] n_angle;

    function automatic logic [PW_W-1:0] abs13(input logic signed [PW_W:0] x);
        return x[PW_W] ? PW_W'(-x) : x[PW_W-1:0];
    endfunction

    function automatic logic [DELAY_W-1:0] abs17(input logic signed [DELAY_W:0] x);
        return x[DELAY_W] ? DELAY_W'(-x) : x[DELAY_W-1:0];
    endfunction

    // angle span after trimming
    always_comb begin
        m_eff     = (r_margin > MARGIN_MAX) ? MARGIN_MAX : r_margin;
        ang_lo    = $signed({1'b0, m_eff}) - HALF_SPAN;
        ang_hi    = HALF_SPAN - $signed({1'b0, m_eff});
        ang_span  = FULL_SPAN - {m_eff, 1'b0};
        if (r_angle < ang_lo) begin
            ang_clamp = ang_lo;
        end else if (r_angle > ang_hi) begin
            ang_clamp = ang_hi;
        end else begin
            ang_clamp = r_angle;
        end
        ang_off   = ang_clamp - ang_lo;
    end

    always_comb begin
        d_pulse  = $signed({1'b0, r_min_pulse}) - $signed({1'b0, r_max_pulse});
        d_ps     = $signed({1'b0, r_pw}) - $signed({1'b0, r_start});
        d_ts     = $signed({1'b0, r_target}) - $signed({1'b0, r_start});
        d_pwmax  = $signed({1'b0, r_pw}) - $signed({1'b0, r_max_pulse});
        d_delay  = $signed({1'b0, r_max_delay}) - $signed({1'b0, r_min_delay});
        wait_dec = (r_wait != '0) ? r_wait - 1'b1 : r_wait;
        step_now = (wait_dec == '0) && (r_pw != r_target);
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        n_neg      = 1'b0;
        n_divisor  = '0;
        n_den_zero = 1'b0;
        case (i_cmd.op)
            OP_DMUL: begin
                mul_a      = abs17(d_delay);
                mul_b      = abs13(d_ps);
                n_neg      = d_delay[DELAY_W] ^ d_ps[PW_W] ^ d_ts[PW_W];
                n_divisor  = abs13(d_ts);
                n_den_zero = (d_ts == '0);
            end
            OP_AMUL: begin
                mul_a      = {{(DELAY_W-ANGLE_W){1'b0}}, ang_off};
                mul_b      = abs13(d_pulse);
                n_neg      = d_pulse[PW_W];
                n_divisor  = {{(DIVR_W-ANGLE_W){1'b0}}, ang_span};
            end
            OP_BMUL: begin
                mul_a      = {{(DELAY_W-PW_W){1'b0}}, abs13(d_pwmax)};
                mul_b      = {{(PW_W-ANGLE_W){1'b0}}, ang_span};
                n_neg      = d_pwmax[PW_W] ^ d_pulse[PW_W];
                n_divisor  = abs13(d_pulse);
                n_den_zero = (d_pulse == '0);
            end
            default: begin
            end
        endcase
        prod = mul_a * mul_b;
    end

    srp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_prod),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // signed quotient and finishing arithmetic
    always_comb begin
        q_s   = r_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        d_sum = $signed({{(PROD_W+2-DELAY_W){1'b0}}, r_min_delay}) + q_s;
        a_sum = $signed({{(PROD_W+2-ANGLE_W){ang_lo[ANGLE_W-1]}}, ang_lo}) + q_s;
        w_new = r_max_pulse + q_s[PW_W-1:0];
        if (r_den_zero) begin
            n_wait = r_max_delay;
        end else if (d_sum < 0) begin
            n_wait = '0;
        end else if (d_sum > $signed((PROD_W+2)'(65535))) begin
            n_wait = '1;
        end else begin
            n_wait = d_sum[DELAY_W-1:0];
        end
        if (r_den_zero) begin
            n_angle = '0;
        end else if (a_sum < -$signed((PROD_W+2)'(90))) begin
            n_angle = -HALF_SPAN;
        end else if (a_sum > $signed((PROD_W+2)'(90))) begin
            n_angle = HALF_SPAN;
        end else begin
            n_angle = a_sum[ANGLE_W-1:0];
        end
    end

    // configuration and servo state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse <= RST_MIN_PULSE;
            r_max_pulse <= RST_MAX_PULSE;
            r_min_delay <= RST_MIN_DELAY;
            r_max_delay <= RST_MAX_DELAY;
            r_margin    <= RST_MARGIN;
            r_pw        <= RST_MID_PULSE;
            r_start     <= RST_MID_PULSE;
            r_target    <= RST_MID_PULSE;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_PULSE: r_min_pulse <= i_cfg_data[PW_W-1:0];
                    CFG_MAX_PULSE: r_max_pulse <= i_cfg_data[PW_W-1:0];
                    CFG_MIN_DELAY: r_min_delay <= i_cfg_data[DELAY_W-1:0];
                    CFG_MAX_DELAY: r_max_delay <= i_cfg_data[DELAY_W-1:0];
                    CFG_MARGIN:    r_margin    <= i_cfg_data[MARGIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                OP_TICK: begin
                    r_wait <= wait_dec;
                    if (step_now) begin
                        r_pw <= (r_target > r_pw) ? r_pw + 1'b1 : r_pw - 1'b1;
                    end
                end
                OP_DFIN: r_wait <= n_wait;
                OP_AFIN: begin
                    if (r_mode == MODE_JUMP) begin
                        r_pw     <= w_new;
                        r_start  <= w_new;
                        r_target <= w_new;
                    end else begin
                        r_start  <= r_pw;
                        r_target <= w_new;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_mode   <= i_mode;
            r_angle  <= i_target_angle;
            r_old_pw <= r_pw;
        end
        if (i_cmd.op == OP_DMUL || i_cmd.op == OP_AMUL || i_cmd.op == OP_BMUL) begin
            r_prod     <= prod;
            r_neg      <= n_neg;
            r_divisor  <= n_divisor;
            r_den_zero <= n_den_zero;
        end
        if (i_cmd.op == OP_BFIN) begin
            r_cur_angle <= n_angle;
        end
        if (i_cmd.op == OP_OUT) begin
            r_out_pw      <= r_pw;
            r_out_changed <= (r_pw != r_old_pw);
            r_out_moving  <= (r_pw != r_target);
            r_out_angle   <= r_cur_angle;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.step_now = step_now;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_pulse_us      = r_out_pw;
    assign o_pulse_changed = r_out_changed;
    assign o_moving        = r_out_moving;
    assign o_current_angle = r_out_angle;

endmodule

>>> sv/srp_ctrl.sv
// Controller state machine: sequences load, tick, multiply, divide and output steps.
// Depends on srp_pkg; talks to srp_datapath through t_dp_cmd and t_dp_stat.
module srp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  srp_pkg::t_dp_stat i_stat,
    output srp_pkg::t_dp_cmd  o_cmd
);
    import srp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode) inside
                    MODE_TICK:             n_state = i_stat.step_now ? S_DMUL : S_BMUL;
                    MODE_RAMP, MODE_JUMP:  n_state = S_AGO;
                    default:               n_state = S_BMUL;
                endcase
            end
            S_DMUL:  n_state = S_DGO;
            S_DGO:   n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_BMUL;
                end
            end
            S_AGO:   n_state = S_AWAIT;
            S_AWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_BMUL;
                end
            end
            S_BMUL:  n_state = S_BGO;
            S_BGO:   n_state = S_BWAIT;
            S_BWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op = OP_NONE;
        o_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_DECODE: begin
                case (i_stat.mode) inside
                    MODE_TICK:            o_cmd.op = OP_TICK;
                    MODE_RAMP, MODE_JUMP: o_cmd.op = OP_AMUL;
                    default:              o_cmd.op = OP_NONE;
                endcase
            end
            S_DMUL:  o_cmd.op = OP_DMUL;
            S_DGO:   o_cmd.op = OP_DIV_GO;
            S_DWAIT: o_cmd.op = i_stat.div_done ? OP_DFIN : OP_NONE;
            S_AGO:   o_cmd.op = OP_DIV_GO;
            S_AWAIT: o_cmd.op = i_stat.div_done ? OP_AFIN : OP_NONE;
            S_BMUL:  o_cmd.op = OP_BMUL;
            S_BGO:   o_cmd.op = OP_DIV_GO;
            S_BWAIT: o_cmd.op = i_stat.div_done ? OP_BFIN : OP_NONE;
            S_OUT:   o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
